// ===== rtl/sorted_keyed_list_engine_unit_defines.svh =====
// assertion macros for the sorted keyed list engine
`ifndef SORTED_KEYED_LIST_ENGINE_UNIT_DEFINES_SVH
`define SORTED_KEYED_LIST_ENGINE_UNIT_DEFINES_SVH

// property holds in the same cycle
`define SKL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// property holds in the cycle after the antecedent
`define SKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sklst_pkg.sv =====
// shared types and constants of the sorted keyed list engine
package sklst_pkg;

  localparam int unsigned CapacityDef    = 64;
  localparam int unsigned PayloadBitsDef = 32;
  localparam int unsigned KeyW           = 32;
  localparam int unsigned PayW           = 32;
  localparam int unsigned PosW           = 8;
  localparam int unsigned CountW         = 7;

  typedef enum logic [2:0] {
    CMD_INS_HEAD   = 3'd0,
    CMD_INS_TAIL   = 3'd1,
    CMD_INS_SORTED = 3'd2,
    CMD_RM_HEAD    = 3'd3,
    CMD_RM_TAIL    = 3'd4,
    CMD_RM_KEY     = 3'd5,
    CMD_READ_POS   = 3'd6,
    CMD_FIND_KEY   = 3'd7
  } cmd_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [KeyW-1:0]   entry_key;
    logic        [PayW-1:0]   entry_payload;
    logic        [PosW-1:0]   position;
  } cmd_t;

  typedef struct packed {
    logic                     ok;
    logic signed [KeyW-1:0]   found_key;
    logic        [PayW-1:0]   found_payload;
    logic        [CountW-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    cmd_e                   command;
    logic signed [KeyW-1:0] entry_key;
    logic        [PosW-1:0] position;
    logic                   cmp_en;
    logic                   commit;
    logic                   ok;
  } cell_ctl_t;

  function automatic logic is_insert(cmd_e c);
    return (c == CMD_INS_HEAD) || (c == CMD_INS_TAIL) || (c == CMD_INS_SORTED);
  endfunction

  function automatic logic is_remove(cmd_e c);
    return (c == CMD_RM_HEAD) || (c == CMD_RM_TAIL) || (c == CMD_RM_KEY);
  endfunction

endpackage

// ===== rtl/sklst_if.sv =====
// command and response channel interfaces
interface sklst_cmd_if;
  import sklst_pkg::*;
  logic valid;
  logic ready;
  cmd_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface sklst_rsp_if;
  import sklst_pkg::*;
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/sorted_keyed_list_engine_unit.sv =====
// sorted keyed list engine: a row of CAPACITY slot cells behind one command port
// a command runs through a compare state, then an execute state that shifts the slots and registers the response
// a new command is taken in the idle state, or in the execute state as the current one commits, never in compare
// a waiting response does not block the next command while its compare runs
// reset: asynchronous, clears the entry count and both channels; slot contents stay undefined
module sorted_keyed_list_engine_unit #(
  parameter int unsigned CAPACITY     = sklst_pkg::CapacityDef,
  parameter int unsigned PAYLOAD_BITS = sklst_pkg::PayloadBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sklst_cmd_if.sink           cmd_i,
  sklst_rsp_if.source         rsp_o
);
  import sklst_pkg::*;

`include "sorted_keyed_list_engine_unit_defines.svh"

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_EXEC
  } state_e;

  state_e             state_q;
  cmd_t               cmd_q;
  logic               ok_q;
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   count_d;
  rsp_t               rsp_q;
  logic               rsp_valid_q;
  logic               out_free;
  logic               accept;
  logic               commit;
  logic               ins;
  logic               rm;
  cell_ctl_t          ctl;

  logic signed [KeyW-1:0]  key_w   [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_w   [CAPACITY];
  logic [CAPACITY:0]       prior_w;
  logic [KeyW-1:0]         acck_w  [CAPACITY+1];
  logic [PAYLOAD_BITS-1:0] accp_w  [CAPACITY+1];
  logic [CAPACITY-1:0]     hit_w;
  logic [PAYLOAD_BITS-1:0] new_pay;

  assign out_free    = !rsp_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) || ((state_q == ST_EXEC) && out_free);
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign commit      = (state_q == ST_EXEC) && out_free;
  assign ins         = is_insert(cmd_q.command);
  assign rm          = is_remove(cmd_q.command);
  assign new_pay     = PAYLOAD_BITS'(cmd_q.entry_payload);

  assign ctl.command   = cmd_q.command;
  assign ctl.entry_key = cmd_q.entry_key;
  assign ctl.position  = cmd_q.position;
  assign ctl.cmp_en    = (state_q == ST_CMP);
  assign ctl.commit    = commit;
  assign ctl.ok        = ok_q;

  assign prior_w[0] = 1'b0;
  assign acck_w[0]  = '0;
  assign accp_w[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KeyW-1:0]  lk;
    logic [PAYLOAD_BITS-1:0] lp;
    logic signed [KeyW-1:0]  rk;
    logic [PAYLOAD_BITS-1:0] rp;
    if (i == 0) begin : g_head
      assign lk = cmd_q.entry_key;
      assign lp = new_pay;
    end else begin : g_mid
      assign lk = key_w[i-1];
      assign lp = pay_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign rk = key_w[i];
      assign rp = pay_w[i];
    end else begin : g_body
      assign rk = key_w[i+1];
      assign rp = pay_w[i+1];
    end
    sklst_cell #(
      .INDEX        (i),
      .CNT_W        (CNT_W),
      .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .count_i     (count_q),
      .new_key_i   (cmd_q.entry_key),
      .new_pay_i   (new_pay),
      .left_key_i  (lk),
      .left_pay_i  (lp),
      .right_key_i (rk),
      .right_pay_i (rp),
      .prior_i     (prior_w[i]),
      .prior_o     (prior_w[i+1]),
      .acc_key_i   (acck_w[i]),
      .acc_pay_i   (accp_w[i]),
      .acc_key_o   (acck_w[i+1]),
      .acc_pay_o   (accp_w[i+1]),
      .key_o       (key_w[i]),
      .pay_o       (pay_w[i]),
      .hit_o       (hit_w[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (ok_q && ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (ok_q && rm) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cmd_q       <= '0;
      ok_q        <= 1'b0;
      count_q     <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i.payload;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          ok_q    <= ins ? (count_q < CAP_C) : prior_w[CAPACITY];
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (commit) begin
            count_q                <= count_d;
            rsp_valid_q            <= 1'b1;
            rsp_q.ok               <= ok_q;
            rsp_q.entry_count      <= CountW'(count_d);
            if (!ok_q) begin
              rsp_q.found_key      <= '0;
              rsp_q.found_payload  <= '0;
            end else if (ins) begin
              rsp_q.found_key      <= cmd_q.entry_key;
              rsp_q.found_payload  <= PayW'(new_pay);
            end else begin
              rsp_q.found_key      <= acck_w[CAPACITY];
              rsp_q.found_payload  <= PayW'(accp_w[CAPACITY]);
            end
            if (accept) begin
              cmd_q   <= cmd_i.payload;
              state_q <= ST_CMP;
            end else begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  `SKL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CAP_C, "entry count above capacity")
  `SKL_ASSERT_NOW(a_single_hit, state_q == ST_EXEC, $onehot0(hit_w), "more than one target slot")
  `SKL_ASSERT_NEXT(a_commit_rsp, commit, rsp_valid_q, "response missing after commit")
  `SKL_ASSERT_NEXT(a_count_hold, !commit, $stable(count_q), "count moved outside commit")
  `SKL_ASSERT_NEXT(a_ins_count, commit && ok_q && ins, count_q == $past(count_q) + CNT_W'(1), "insert did not grow count")

endmodule

// ===== rtl/sklst_cell.sv =====
// one list slot: key compare, first-hit chain, shift and readout
module sklst_cell #(
  parameter int unsigned INDEX        = 0,
  parameter int unsigned CNT_W        = 7,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sklst_pkg::cell_ctl_t          ctl_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic signed [sklst_pkg::KeyW-1:0] new_key_i,
  input  logic [PAYLOAD_BITS-1:0]       new_pay_i,
  input  logic signed [sklst_pkg::KeyW-1:0] left_key_i,
  input  logic [PAYLOAD_BITS-1:0]       left_pay_i,
  input  logic signed [sklst_pkg::KeyW-1:0] right_key_i,
  input  logic [PAYLOAD_BITS-1:0]       right_pay_i,
  input  logic                          prior_i,
  output logic                          prior_o,
  input  logic [sklst_pkg::KeyW-1:0]    acc_key_i,
  input  logic [PAYLOAD_BITS-1:0]       acc_pay_i,
  output logic [sklst_pkg::KeyW-1:0]    acc_key_o,
  output logic [PAYLOAD_BITS-1:0]       acc_pay_o,
  output logic signed [sklst_pkg::KeyW-1:0] key_o,
  output logic [PAYLOAD_BITS-1:0]       pay_o,
  output logic                          hit_o
);
  import sklst_pkg::*;

  localparam int unsigned PCW = (CNT_W > PosW) ? CNT_W : PosW;
  localparam logic [CNT_W-1:0] IDX  = CNT_W'(INDEX);
  localparam logic [CNT_W-1:0] IDX1 = CNT_W'(INDEX + 1);
  localparam logic [PCW-1:0]   POS1 = PCW'(INDEX + 1);

  logic signed [KeyW-1:0]   key_q;
  logic [PAYLOAD_BITS-1:0]  pay_q;
  logic                     hit_q;
  logic                     above_q;
  logic                     valid;
  logic                     cond;
  logic                     term;
  logic                     ins;

  assign valid = IDX < count_i;
  assign ins   = is_insert(ctl_i.command);

  always_comb begin
    case (ctl_i.command)
      CMD_INS_HEAD:   cond = 1'b1;
      CMD_INS_TAIL:   cond = 1'b0;
      CMD_INS_SORTED: cond = !(key_q < ctl_i.entry_key);
      CMD_RM_HEAD:    cond = 1'b1;
      CMD_RM_TAIL:    cond = (IDX1 == count_i);
      CMD_RM_KEY:     cond = (key_q == ctl_i.entry_key);
      CMD_READ_POS:   cond = (PCW'(ctl_i.position) == POS1);
      CMD_FIND_KEY:   cond = (key_q == ctl_i.entry_key);
      default:        cond = 1'b0;
    endcase
  end

  assign term    = valid ? cond : ins;
  assign prior_o = prior_i | term;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q   <= 1'b0;
      above_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      hit_q   <= term & !prior_i;
      above_q <= prior_i;
    end
  end

  // shift toward the tail on insert, toward the head on remove
  always_ff @(posedge clk_i) begin
    if (ctl_i.commit && ctl_i.ok) begin
      if (ins) begin
        if (hit_q) begin
          key_q <= new_key_i;
          pay_q <= new_pay_i;
        end else if (above_q) begin
          key_q <= left_key_i;
          pay_q <= left_pay_i;
        end
      end else if (is_remove(ctl_i.command) && (hit_q || above_q)) begin
        key_q <= right_key_i;
        pay_q <= right_pay_i;
      end
    end
  end

  assign acc_key_o = acc_key_i | (hit_q ? key_q : '0);
  assign acc_pay_o = acc_pay_i | (hit_q ? pay_q : '0);
  assign key_o     = key_q;
  assign pay_o     = pay_q;
  assign hit_o     = hit_q;

endmodule

// ===== tb/sorted_keyed_list_engine_unit_checker.sv =====
`timescale 1ns / 1ps
// checker that keeps a shadow copy of the list, predicts each response and compares beats
module sorted_keyed_list_engine_unit_checker #(
  parameter int unsigned CAPACITY     = sklst_pkg::CapacityDef,
  parameter int unsigned PAYLOAD_BITS = sklst_pkg::PayloadBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  logic              cmd_ready_i,
  input  sklst_pkg::cmd_t   cmd_i,
  input  logic              rsp_valid_i,
  input  logic              rsp_ready_i,
  input  sklst_pkg::rsp_t   rsp_i,
  output int                outstanding_o,
  output int                fail_count_o
);
  import sklst_pkg::*;

  localparam logic [PayW-1:0] PayMask =
    (PAYLOAD_BITS >= PayW) ? '1 : PayW'((64'd1 << PAYLOAD_BITS) - 64'd1);

  logic signed [KeyW-1:0] shadow_keys [CAPACITY];
  logic        [PayW-1:0] shadow_pays [CAPACITY];
  int                     shadow_len = 0;
  rsp_t                   expected_rsp_q [$];
  int                     fails = 0;

  assign fail_count_o = fails;

  function automatic int first_with_key(logic signed [KeyW-1:0] k);
    int i;
    i = 0;
    while (i < shadow_len && shadow_keys[i] != k) i++;
    return i;
  endfunction

  function automatic rsp_t apply_command(cmd_t c);
    rsp_t r;
    int   idx;
    r   = '0;
    idx = 0;
    case (c.command)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_SORTED: begin
        if (shadow_len < int'(CAPACITY)) begin
          if (c.command == CMD_INS_TAIL) begin
            idx = shadow_len;
          end else if (c.command == CMD_INS_SORTED) begin
            while (idx < shadow_len && $signed(shadow_keys[idx]) < $signed(c.entry_key)) idx++;
          end
          for (int i = shadow_len; i > idx; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_pays[i] = shadow_pays[i-1];
          end
          shadow_keys[idx] = c.entry_key;
          shadow_pays[idx] = c.entry_payload & PayMask;
          shadow_len++;
          r.ok            = 1'b1;
          r.found_key     = shadow_keys[idx];
          r.found_payload = shadow_pays[idx];
        end
      end
      CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_KEY: begin
        if (c.command == CMD_RM_TAIL) begin
          idx = shadow_len - 1;
        end else if (c.command == CMD_RM_KEY) begin
          idx = first_with_key(c.entry_key);
        end
        if (shadow_len > 0 && idx < shadow_len) begin
          r.ok            = 1'b1;
          r.found_key     = shadow_keys[idx];
          r.found_payload = shadow_pays[idx];
          for (int i = idx; i + 1 < shadow_len; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
          end
          shadow_len--;
        end
      end
      CMD_READ_POS: begin
        idx = (c.position >= 1 && int'(c.position) <= shadow_len) ?
              int'(c.position) - 1 : shadow_len;
        if (idx < shadow_len) begin
          r.ok            = 1'b1;
          r.found_key     = shadow_keys[idx];
          r.found_payload = shadow_pays[idx];
        end
      end
      default: begin
        idx = first_with_key(c.entry_key);
        if (idx < shadow_len) begin
          r.ok            = 1'b1;
          r.found_key     = shadow_keys[idx];
          r.found_payload = shadow_pays[idx];
        end
      end
    endcase
    r.entry_count = CountW'(shadow_len);
    return r;
  endfunction

  function automatic int field_differs(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      shadow_len = 0;
      expected_rsp_q.delete();
      outstanding_o <= 0;
    end else begin
      if (rsp_valid_i === 1'b1 && rsp_ready_i === 1'b1) begin
        if (expected_rsp_q.size() == 0) begin
          $error("response beat with no command outstanding");
          fails++;
        end else begin
          want = expected_rsp_q.pop_front();
          fails += field_differs("ok", 32'(want.ok), 32'(rsp_i.ok))
                 + field_differs("found_key", want.found_key, rsp_i.found_key)
                 + field_differs("found_payload", want.found_payload, rsp_i.found_payload)
                 + field_differs("entry_count", 32'(want.entry_count),
                                 32'(rsp_i.entry_count));
        end
      end
      if (cmd_valid_i === 1'b1 && cmd_ready_i === 1'b1) begin
        expected_rsp_q.push_back(apply_command(cmd_i));
      end
      outstanding_o <= expected_rsp_q.size();
    end
  end

endmodule

// ===== tb/sorted_keyed_list_engine_unit_test.sv =====
`timescale 1ns / 1ps
// testbench top: clock, reset, command stimulus under idle patterns, and the verdict
module sorted_keyed_list_engine_unit_test;
  import sklst_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 100;
  localparam int SendIdle [3] = '{12, 75, 0};
  localparam int RecvIdle [3] = '{75, 12, 0};
  localparam logic signed [KeyW-1:0] KeyMin = {1'b1, {(KeyW-1){1'b0}}};
  localparam logic signed [KeyW-1:0] KeyMax = {1'b0, {(KeyW-1){1'b1}}};

  logic clk_i = 1'b0;
  logic rst_ni;
  int   send_idle_pct = SendIdle[0];
  int   recv_idle_pct = RecvIdle[0];
  int   cycles = 0;
  int   outstanding;
  int   fail_count;

  sklst_cmd_if cmd_if ();
  sklst_rsp_if rsp_if ();

  sorted_keyed_list_engine_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .rsp_o  (rsp_if)
  );

  sorted_keyed_list_engine_unit_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_if.valid),
    .cmd_ready_i   (cmd_if.ready),
    .cmd_i         (cmd_if.payload),
    .rsp_valid_i   (rsp_if.valid),
    .rsp_ready_i   (rsp_if.ready),
    .rsp_i         (rsp_if.payload),
    .outstanding_o (outstanding),
    .fail_count_o  (fail_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic cmd_e pick_command(int ins_pct, int rm_pct);
    cmd_e inserts [3] = '{CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_SORTED};
    cmd_e removes [3] = '{CMD_RM_HEAD, CMD_RM_TAIL, CMD_RM_KEY};
    cmd_e lookups [2] = '{CMD_READ_POS, CMD_FIND_KEY};
    int   r;
    r = $urandom_range(0, 99);
    if (r < ins_pct) return inserts[$urandom_range(0, 2)];
    if (r < ins_pct + rm_pct) return removes[$urandom_range(0, 2)];
    return lookups[$urandom_range(0, 1)];
  endfunction

  // small keys make duplicates and key hits common
  function automatic logic signed [KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return int'($urandom_range(0, 16)) - 8;
    if (r < 8) return $urandom();
    if (r == 8) return KeyMin;
    return KeyMax;
  endfunction

  function automatic logic [PosW-1:0] pick_position();
    if ($urandom_range(0, 99) < 80) return PosW'($urandom_range(0, 66));
    return PosW'($urandom_range(0, 255));
  endfunction

  task automatic send_command(input cmd_e op, input logic signed [KeyW-1:0] key,
                              input logic [PayW-1:0] pay, input logic [PosW-1:0] pos);
    cmd_t c;
    c.command       = op;
    c.entry_key     = key;
    c.entry_payload = pay;
    c.position      = pos;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    @(posedge clk_i);
    while (cmd_if.ready !== 1'b1) @(posedge clk_i);
  endtask

  task automatic wait_all_responses();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(int ins_pct, int rm_pct);
    repeat (PhaseItems) begin
      send_command(pick_command(ins_pct, rm_pct), pick_key(), $urandom(), pick_position());
    end
    wait_all_responses();
  endtask

  initial begin
    rst_ni         <= 1'b0;
    cmd_if.valid   <= 1'b0;
    cmd_if.payload <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list
    send_command(CMD_RM_HEAD, '0, '0, '0);
    send_command(CMD_RM_TAIL, '0, '0, '0);
    send_command(CMD_RM_KEY, '0, '0, '0);
    send_command(CMD_READ_POS, '0, '0, 8'd1);
    send_command(CMD_FIND_KEY, '0, '0, '0);
    // sorted inserts with extreme keys, equal key goes first
    send_command(CMD_INS_SORTED, '0, '0, '0);
    send_command(CMD_INS_SORTED, KeyMax, '1, '0);
    send_command(CMD_INS_SORTED, KeyMin, 32'ha5a5a5a5, '0);
    send_command(CMD_INS_SORTED, -1, 32'h5a5a5a5a, '0);
    send_command(CMD_INS_SORTED, '0, 32'd1, '1);
    send_command(CMD_INS_HEAD, 5, 32'h12345678, '0);
    send_command(CMD_INS_TAIL, -5, 32'h87654321, '0);
    // reads at and past the bounds
    send_command(CMD_READ_POS, '0, '0, 8'd0);
    send_command(CMD_READ_POS, '0, '0, 8'd1);
    send_command(CMD_READ_POS, '0, '0, 8'd7);
    send_command(CMD_READ_POS, '0, '0, 8'd8);
    send_command(CMD_READ_POS, '0, '0, '1);
    // key lookups and removals, present and absent
    send_command(CMD_FIND_KEY, '0, '0, '0);
    send_command(CMD_FIND_KEY, 12345, '0, '0);
    send_command(CMD_RM_KEY, '0, '0, '0);
    send_command(CMD_RM_KEY, 999, '0, '0);
    send_command(CMD_RM_TAIL, '0, '0, '0);
    send_command(CMD_RM_HEAD, '0, '0, '0);
    wait_all_responses();

    for (int m = 0; m < 3; m++) begin
      send_idle_pct = SendIdle[m];
      recv_idle_pct = RecvIdle[m];
      run_phase(90, 5);
      run_phase(40, 35);
      run_phase(5, 85);
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
